/* hdl/wud_pkg.sv */
// ----------------------------------------------------------------------------
// wud_pkg: shared types and constants for the wide unsigned divider
// Command codes, port field widths and the per-stage control word.
// ----------------------------------------------------------------------------
package wud_pkg;

  localparam int FIELD_BITS = 64;
  localparam int CMD_BITS   = 3;

  localparam logic [CMD_BITS-1:0] CMD_DIV_2BY1 = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_MOD_2BY1 = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_DIV_2BY2 = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_MOD_2BY2 = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_DIV_3BY2 = 3'd4;

  // Control word that travels down the cell chain beside the data.
  typedef struct packed {
    logic valid;
    logic want_rem;    // return remainder instead of quotient
    logic force_zero;  // unused command or zero divisor: answer is 0
    logic dz;          // zero divisor flag
  } wud_ctrl_t;

endpackage

/* hdl/wide_unsigned_divider.sv */
// ----------------------------------------------------------------------------
// wide_unsigned_divider: pipelined multiword unsigned divider
// Every command is mapped onto a 3-word dividend and a 2-word divisor and
// runs through a chain of 3*WORD_BITS restoring division cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries command and five operand words;
//   output channel out_valid/out_ready carries answer and divide_by_zero.
//   One transfer per cycle is taken on each side while out_ready stays high.
//   The pipeline holds one cell per dividend bit, each a shift, a
//   2*WORD_BITS+1 bit subtract and a select, followed by the output
//   register.
//   Words are taken at their low WORD_BITS bits; answer is zero extended.
//   A zero divisor gives answer 0 with divide_by_zero set; command codes
//   above 4 give answer 0 with the flag clear.
//   Reset clears every cell valid bit and the output buffer; in_ready is
//   high in the first cycle after reset.
//   When the receiver stalls, one more result is caught in a skid slot;
//   after that the whole cell chain holds and in_ready drops until the
//   result in the output register is taken.
// ----------------------------------------------------------------------------
module wide_unsigned_divider #(
  parameter int WORD_BITS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [wud_pkg::CMD_BITS-1:0]      command,
  input  logic [wud_pkg::FIELD_BITS-1:0]    first_word,
  input  logic [wud_pkg::FIELD_BITS-1:0]    second_word,
  input  logic [wud_pkg::FIELD_BITS-1:0]    third_word,
  input  logic [wud_pkg::FIELD_BITS-1:0]    fourth_word,
  input  logic [wud_pkg::FIELD_BITS-1:0]    fifth_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [wud_pkg::FIELD_BITS-1:0]    answer,
  output logic                              divide_by_zero
);
  import wud_pkg::*;

  localparam int CELLS    = 3 * WORD_BITS;
  localparam int NUM_BITS = 3 * WORD_BITS;
  localparam int REM_BITS = 2 * WORD_BITS;

  logic [WORD_BITS-1:0] w1, w2, w3, w4, w5;
  logic [NUM_BITS-1:0]  num0;
  logic [REM_BITS-1:0]  den0;
  logic                 cmd_ok;
  logic                 want_rem;
  wud_ctrl_t            ctrl0;
  logic                 en;

  wud_ctrl_t            ctrl_pipe [0:CELLS];
  logic [NUM_BITS-1:0]  num_pipe  [0:CELLS];
  logic [REM_BITS-1:0]  den_pipe  [0:CELLS];
  logic [REM_BITS-1:0]  rem_pipe  [0:CELLS];
  logic [WORD_BITS-1:0] quo_pipe  [0:CELLS];

  // Short dividends get leading zero words; those only add leading zero
  // quotient bits, so every command runs the same number of steps.
  always_comb begin
    w1       = first_word[WORD_BITS-1:0];
    w2       = second_word[WORD_BITS-1:0];
    w3       = third_word[WORD_BITS-1:0];
    w4       = fourth_word[WORD_BITS-1:0];
    w5       = fifth_word[WORD_BITS-1:0];
    num0     = {{WORD_BITS{1'b0}}, w1, w2};
    den0     = '0;
    cmd_ok   = 1'b1;
    want_rem = 1'b0;
    case (command)
      CMD_DIV_2BY1: begin
        den0 = {{WORD_BITS{1'b0}}, w3};
      end
      CMD_MOD_2BY1: begin
        den0     = {{WORD_BITS{1'b0}}, w3};
        want_rem = 1'b1;
      end
      CMD_DIV_2BY2: begin
        den0 = {w3, w4};
      end
      CMD_MOD_2BY2: begin
        den0     = {w3, w4};
        want_rem = 1'b1;
      end
      CMD_DIV_3BY2: begin
        num0 = {w1, w2, w3};
        den0 = {w4, w5};
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase
    ctrl0.valid      = in_valid;
    ctrl0.want_rem   = want_rem;
    ctrl0.dz         = cmd_ok & (den0 == '0);
    ctrl0.force_zero = ~cmd_ok | (den0 == '0);
  end

  assign in_ready     = en;
  assign ctrl_pipe[0] = ctrl0;
  assign num_pipe[0]  = num0;
  assign den_pipe[0]  = den0;
  assign rem_pipe[0]  = '0;
  assign quo_pipe[0]  = '0;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    wud_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctrl_in  (ctrl_pipe[i]),
      .num_in   (num_pipe[i]),
      .den_in   (den_pipe[i]),
      .rem_in   (rem_pipe[i]),
      .quo_in   (quo_pipe[i]),
      .ctrl_out (ctrl_pipe[i+1]),
      .num_out  (num_pipe[i+1]),
      .den_out  (den_pipe[i+1]),
      .rem_out  (rem_pipe[i+1]),
      .quo_out  (quo_pipe[i+1])
    );
  end

  wud_out #(
    .WORD_BITS (WORD_BITS)
  ) u_out (
    .clk            (clk),
    .rst            (rst),
    .take           (en & ctrl_pipe[CELLS].valid),
    .ctrl           (ctrl_pipe[CELLS]),
    .rem_low        (rem_pipe[CELLS][WORD_BITS-1:0]),
    .quo            (quo_pipe[CELLS]),
    .room           (en),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .answer         (answer),
    .divide_by_zero (divide_by_zero)
  );

endmodule

/* hdl/wud_cell.sv */
// ----------------------------------------------------------------------------
// wud_cell: one restoring division step
// Shifts one dividend bit into the partial remainder, compares against the
// divisor, subtracts when it fits and appends the quotient bit.
// ----------------------------------------------------------------------------
module wud_cell #(
  parameter int WORD_BITS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  wud_pkg::wud_ctrl_t        ctrl_in,
  input  logic [3*WORD_BITS-1:0]    num_in,
  input  logic [2*WORD_BITS-1:0]    den_in,
  input  logic [2*WORD_BITS-1:0]    rem_in,
  input  logic [WORD_BITS-1:0]      quo_in,
  output wud_pkg::wud_ctrl_t        ctrl_out,
  output logic [3*WORD_BITS-1:0]    num_out,
  output logic [2*WORD_BITS-1:0]    den_out,
  output logic [2*WORD_BITS-1:0]    rem_out,
  output logic [WORD_BITS-1:0]      quo_out
);
  import wud_pkg::*;

  localparam int NUM_BITS = 3 * WORD_BITS;
  localparam int REM_BITS = 2 * WORD_BITS;

  wud_ctrl_t             ctrl;
  logic [NUM_BITS-1:0]   num;
  logic [REM_BITS-1:0]   den;
  logic [REM_BITS-1:0]   rem;
  logic [WORD_BITS-1:0]  quo;

  logic [REM_BITS:0]     rem_sh;
  logic [REM_BITS+1:0]   diff;
  logic                  fits;
  logic [REM_BITS-1:0]   rem_next;

  always_comb begin
    rem_sh   = {rem_in, num_in[NUM_BITS-1]};
    diff     = {1'b0, rem_sh} - {2'b00, den_in};
    fits     = ~diff[REM_BITS+1];
    // after a subtract the remainder is below the divisor, so it fits
    rem_next = fits ? diff[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else if (en) begin
      ctrl <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num <= {num_in[NUM_BITS-2:0], 1'b0};
      den <= den_in;
      rem <= rem_next;
      quo <= {quo_in[WORD_BITS-2:0], fits};
    end
  end

  assign ctrl_out = ctrl;
  assign num_out  = num;
  assign den_out  = den;
  assign rem_out  = rem;
  assign quo_out  = quo;

endmodule

/* hdl/wud_out.sv */
// ----------------------------------------------------------------------------
// wud_out: result select and output skid buffer
// Picks quotient, remainder or zero, and holds up to two results so the cell
// chain can deliver one more result after the receiver stalls.
// ----------------------------------------------------------------------------
module wud_out #(
  parameter int WORD_BITS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  wud_pkg::wud_ctrl_t                  ctrl,
  input  logic [WORD_BITS-1:0]                rem_low,
  input  logic [WORD_BITS-1:0]                quo,
  output logic                                room,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wud_pkg::FIELD_BITS-1:0]      answer,
  output logic                                divide_by_zero
);
  import wud_pkg::*;

  logic [WORD_BITS-1:0]  sel;
  logic [FIELD_BITS-1:0] new_answer;
  logic                  pop;

  logic                  skid_valid;
  logic [FIELD_BITS-1:0] skid_answer;
  logic                  skid_dz;

  always_comb begin
    if (ctrl.force_zero) begin
      sel = '0;
    end else if (ctrl.want_rem) begin
      sel = rem_low;
    end else begin
      sel = quo;
    end
    new_answer = FIELD_BITS'(sel);
    pop        = out_valid & out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (take) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        answer         <= skid_answer;
        divide_by_zero <= skid_dz;
      end
    end else if (take) begin
      if (!out_valid || pop) begin
        answer         <= new_answer;
        divide_by_zero <= ctrl.dz;
      end else begin
        skid_answer <= new_answer;
        skid_dz     <= ctrl.dz;
      end
    end
  end

  // chain advances only while the skid slot is free
  assign room = ~skid_valid;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !take)
    else $error("cell chain advanced into a full skid buffer");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !pop |=> skid_valid && $stable(skid_answer) && $stable(skid_dz))
    else $error("skid entry lost or changed while stalled");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> answer == '0)
    else $error("nonzero answer reported with zero divisor");

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for wide_unsigned_divider
// Drives directed and random divisions of every command through the
// valid/ready input channel, predicts each answer with wide integer
// arithmetic and checks the results in order, under varying idle and stall
// patterns on both channels, including one long output stall.
// ----------------------------------------------------------------------------
module testbench;
  import wud_pkg::*;

  localparam int WORD_BITS      = 64;
  localparam int PIPE_LATENCY   = 3 * WORD_BITS + 1;
  localparam int DRAIN_CYCLES   = PIPE_LATENCY + 20;
  localparam int HOLD_CYCLES    = 4 * PIPE_LATENCY;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int RANDOM_PER_PHASE = 450;

  localparam logic [FIELD_BITS-1:0] WORD_MASK = {FIELD_BITS{1'b1}} >> (FIELD_BITS - WORD_BITS);
  localparam logic [CMD_BITS-1:0]   CMD_FIRST_UNUSED = CMD_DIV_3BY2 + 1'b1;
  localparam logic [CMD_BITS-1:0]   CMD_LAST_CODE    = '1;

  typedef struct packed {
    logic [FIELD_BITS-1:0] answer;
    logic                  divide_by_zero;
  } div_result_t;

  // Holds the answers still owed by the divider, oldest first.
  class division_scoreboard;
    div_result_t owed_answers[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function div_result_t predict_division(logic [CMD_BITS-1:0] cmd,
                                           logic [FIELD_BITS-1:0] w1,
                                           logic [FIELD_BITS-1:0] w2,
                                           logic [FIELD_BITS-1:0] w3,
                                           logic [FIELD_BITS-1:0] w4,
                                           logic [FIELD_BITS-1:0] w5);
      logic [3*FIELD_BITS-1:0] m1, m2, m3, m4, m5;
      logic [3*FIELD_BITS-1:0] dividend, divisor, ratio, leftover;
      div_result_t r;
      r  = '0;
      m1 = w1 & WORD_MASK;
      m2 = w2 & WORD_MASK;
      m3 = w3 & WORD_MASK;
      m4 = w4 & WORD_MASK;
      m5 = w5 & WORD_MASK;
      case (cmd)
        CMD_DIV_2BY1, CMD_MOD_2BY1: begin
          dividend = (m1 << WORD_BITS) | m2;
          divisor  = m3;
        end
        CMD_DIV_2BY2, CMD_MOD_2BY2: begin
          dividend = (m1 << WORD_BITS) | m2;
          divisor  = (m3 << WORD_BITS) | m4;
        end
        CMD_DIV_3BY2: begin
          dividend = (m1 << (2 * WORD_BITS)) | (m2 << WORD_BITS) | m3;
          divisor  = (m4 << WORD_BITS) | m5;
        end
        default: return r;
      endcase
      if (divisor == '0) begin
        r.divide_by_zero = 1'b1;
        return r;
      end
      ratio    = dividend / divisor;
      leftover = dividend % divisor;
      if (cmd == CMD_MOD_2BY1 || cmd == CMD_MOD_2BY2)
        r.answer = leftover[FIELD_BITS-1:0] & WORD_MASK;
      else
        r.answer = ratio[FIELD_BITS-1:0] & WORD_MASK;
      return r;
    endfunction

    function void note_operation(logic [CMD_BITS-1:0] cmd,
                                 logic [FIELD_BITS-1:0] w1, logic [FIELD_BITS-1:0] w2,
                                 logic [FIELD_BITS-1:0] w3, logic [FIELD_BITS-1:0] w4,
                                 logic [FIELD_BITS-1:0] w5);
      owed_answers.push_back(predict_division(cmd, w1, w2, w3, w4, w5));
    endfunction

    function void check_result(logic [FIELD_BITS-1:0] answer, logic divide_by_zero);
      div_result_t exp_res;
      if (owed_answers.size() == 0) begin
        $error("result with nothing outstanding: answer=%h divide_by_zero=%b",
               answer, divide_by_zero);
        mismatches++;
        return;
      end
      exp_res = owed_answers.pop_front();
      if (answer !== exp_res.answer) begin
        $error("answer: expected %h, actual %h", exp_res.answer, answer);
        mismatches++;
      end
      if (divide_by_zero !== exp_res.divide_by_zero) begin
        $error("divide_by_zero: expected %b, actual %b",
               exp_res.divide_by_zero, divide_by_zero);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return owed_answers.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst         = 1'b1;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [CMD_BITS-1:0]   command     = CMD_DIV_2BY1;
  logic [FIELD_BITS-1:0] first_word  = '0;
  logic [FIELD_BITS-1:0] second_word = '0;
  logic [FIELD_BITS-1:0] third_word  = '0;
  logic [FIELD_BITS-1:0] fourth_word = '0;
  logic [FIELD_BITS-1:0] fifth_word  = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [FIELD_BITS-1:0] answer;
  logic                  divide_by_zero;

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  bit          hold_request       = 1'b0;
  int unsigned cycle_count        = 0;

  division_scoreboard sb = new();

  wide_unsigned_divider #(.WORD_BITS(WORD_BITS)) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .first_word     (first_word),
    .second_word    (second_word),
    .third_word     (third_word),
    .fourth_word    (fourth_word),
    .fifth_word     (fifth_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .answer         (answer),
    .divide_by_zero (divide_by_zero)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Both transfers are observed on the rising edge, before any update lands.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_operation(command, first_word, second_word, third_word,
                          fourth_word, fifth_word);
      if (out_valid && out_ready)
        sb.check_result(answer, divide_by_zero);
    end
  end

  // Receiver: random stalls, or a long hold-off when requested.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_ready   <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Leaves in_valid high on return so back-to-back transfers need no toggle.
  task automatic send_op(input logic [CMD_BITS-1:0] cmd,
                         input logic [FIELD_BITS-1:0] w1, input logic [FIELD_BITS-1:0] w2,
                         input logic [FIELD_BITS-1:0] w3, input logic [FIELD_BITS-1:0] w4,
                         input logic [FIELD_BITS-1:0] w5);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    first_word  <= w1;
    second_word <= w2;
    third_word  <= w3;
    fourth_word <= w4;
    fifth_word  <= w5;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [FIELD_BITS-1:0] random_word();
    logic [FIELD_BITS-1:0] w;
    case ($urandom_range(19))
      0:       w = '0;
      1:       w = '1;
      2, 3:    w = FIELD_BITS'($urandom_range(1, 255));
      4:       w = FIELD_BITS'(1) << $urandom_range(FIELD_BITS - 1);
      5:       w = '1 - FIELD_BITS'($urandom_range(1, 255));
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  task automatic send_random_batch(input int unsigned count);
    logic [CMD_BITS-1:0]   cmd;
    logic [FIELD_BITS-1:0] w1, w2, w3, w4, w5;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(19) == 0)
        cmd = CMD_BITS'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
      else
        cmd = CMD_BITS'($urandom_range(CMD_DIV_2BY1, CMD_DIV_3BY2));
      w1 = random_word();
      w2 = random_word();
      w3 = random_word();
      w4 = random_word();
      w5 = random_word();
      // zero divisor now and then, for every divisor width
      if ($urandom_range(24) == 0) begin
        case (cmd)
          CMD_DIV_2BY1, CMD_MOD_2BY1: w3 = '0;
          CMD_DIV_2BY2, CMD_MOD_2BY2: begin w3 = '0; w4 = '0; end
          CMD_DIV_3BY2:               begin w4 = '0; w5 = '0; end
          default: ;
        endcase
      end
      // for 2by1 and 3by2 commands, keep the quotient inside one word about a third of the time
      if ($urandom_range(2) == 0) begin
        if ((cmd == CMD_DIV_2BY1 || cmd == CMD_MOD_2BY1) && w3 != '0)
          w1 = w1 % w3;
        else if (cmd == CMD_DIV_3BY2 && w4 != '0)
          w1 = w1 % w4;
      end
      send_op(cmd, w1, w2, w3, w4, w5);
    end
  endtask

  initial begin
    logic [FIELD_BITS-1:0] ones;
    logic [FIELD_BITS-1:0] zero;
    ones = '1;
    zero = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, every command, zero divisors, unused codes
    send_op(CMD_DIV_2BY1, ones, ones, ones, zero, zero);
    send_op(CMD_MOD_2BY1, ones, ones, ones - 1'b1, zero, zero);
    send_op(CMD_DIV_2BY2, ones, ones, ones, ones, zero);
    send_op(CMD_MOD_2BY2, ones, ones, ones, ones - 1'b1, zero);
    send_op(CMD_DIV_3BY2, ones, ones, ones, ones, ones);
    send_op(CMD_DIV_2BY1, ones, ones, FIELD_BITS'(1), ones, ones);   // wide quotient
    send_op(CMD_DIV_3BY2, ones, ones, ones, zero, FIELD_BITS'(1));   // wide quotient
    send_op(CMD_DIV_2BY2, ones, ones, zero, FIELD_BITS'(1), ones);
    send_op(CMD_DIV_2BY1, ones, ones, zero, ones, ones);             // zero divisor
    send_op(CMD_MOD_2BY1, FIELD_BITS'(5), FIELD_BITS'(7), zero, zero, zero);
    send_op(CMD_DIV_2BY2, ones, ones, zero, zero, ones);
    send_op(CMD_MOD_2BY2, ones, ones, zero, zero, ones);
    send_op(CMD_DIV_3BY2, ones, ones, ones, zero, zero);
    send_op(CMD_DIV_2BY1, zero, zero, FIELD_BITS'(1), zero, zero);
    send_op(CMD_MOD_2BY2, zero, FIELD_BITS'(9), zero, FIELD_BITS'(1), zero);
    send_op(CMD_DIV_3BY2, zero, zero, FIELD_BITS'(3), ones, ones);
    send_op(CMD_MOD_2BY1, zero, FIELD_BITS'(3), FIELD_BITS'(4), zero, zero);
    send_op(CMD_FIRST_UNUSED, ones, ones, ones, ones, ones);
    send_op(CMD_FIRST_UNUSED + 1'b1, zero, zero, zero, zero, zero);
    send_op(CMD_LAST_CODE, {$urandom, $urandom}, {$urandom, $urandom},
            {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});

    // no idling, and the receiver holds off long enough to back up the chain
    hold_request = 1'b1;
    send_random_batch(RANDOM_PER_PHASE);

    sender_idle_pct = 48;
    receiver_stall_pct = 0;
    send_random_batch(RANDOM_PER_PHASE);

    sender_idle_pct = 0;
    receiver_stall_pct = 48;
    send_random_batch(RANDOM_PER_PHASE);

    sender_idle_pct = 10;
    receiver_stall_pct = 10;
    send_random_batch(RANDOM_PER_PHASE);

    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
hdl/wud_pkg.sv
hdl/wud_cell.sv
hdl/wud_out.sv
hdl/wide_unsigned_divider.sv
sim/testbench.sv
